/* design/ps_pkg.sv */
// Shared types and constants for the coordinate point sorter.
package ps_pkg;

	localparam int COORD_W = 32;
	localparam int MAX_POINTS_DEF = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_AXIS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SORT_ORDER = 2'd1;

	localparam logic [CFG_DATA_W-1:0] AXIS_X = 2'd0;
	localparam logic [CFG_DATA_W-1:0] AXIS_Y = 2'd1;
	localparam logic [CFG_DATA_W-1:0] ORDER_ASC = 2'd0;
	localparam logic [CFG_DATA_W-1:0] ORDER_DESC = 2'd1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	typedef struct packed {
		logic by_y;
		logic desc;
		logic bad;
	} sort_cfg_t;

endpackage

/* design/point_sort_by_coordinate_core.sv */
// Top level of the coordinate point sorter with its configuration registers.
// Points are loaded one transfer per cycle into a MAX_POINTS-entry store until a transfer
// marked final_point; points beyond MAX_POINTS are dropped. The held set of n points
// is then exchange sorted in place: each pass i keeps entry i in a register and
// streams entries i+1..n-1 through the single store read port, one compare per
// cycle, and writes the held entry back to slot i when the pass ends.
// An invalid key_axis or sort_order skips the sort and flags every output point.
// Results then leave one transfer per cycle while out_ready stays high, and a
// new set is accepted once the last point has moved into the output register.
module point_sort_by_coordinate_core
	import ps_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic                      final_point,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] sorted_x,
	output logic signed [COORD_W-1:0] sorted_y,
	output logic                      end_of_set,
	output logic                      bad_params
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [CFG_DATA_W-1:0] key_axis_q;
	logic [CFG_DATA_W-1:0] sort_order_q;
	sort_cfg_t             cfg;
	point_t                in_pt;
	point_t                out_pt;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	point_t                mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	point_t                mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_axis_q <= AXIS_X;
			sort_order_q <= ORDER_ASC;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_KEY_AXIS) begin
				key_axis_q <= cfg_data;
			end else if (cfg_index == REG_SORT_ORDER) begin
				sort_order_q <= cfg_data;
			end
		end
	end

	assign cfg.by_y = (key_axis_q == AXIS_Y);
	assign cfg.desc = (sort_order_q == ORDER_DESC);
	assign cfg.bad = (key_axis_q != AXIS_X && key_axis_q != AXIS_Y)
		|| (sort_order_q != ORDER_ASC && sort_order_q != ORDER_DESC);

	assign in_pt.x = point_x;
	assign in_pt.y = point_y;
	assign sorted_x = out_pt.x;
	assign sorted_y = out_pt.y;

	ps_seq #(
		.MAX_POINTS(MAX_POINTS),
		.AW(AW),
		.CW(CW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_pt(in_pt),
		.in_final(final_point),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_pt(out_pt),
		.out_last(end_of_set),
		.out_bad(bad_params),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ps_mem #(
		.DEPTH(MAX_POINTS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

/* design/ps_mem.sv */
// Point store: one write port and one registered read port.
module ps_mem
	import ps_pkg::*;
#(
	parameter int DEPTH = MAX_POINTS_DEF,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  point_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output point_t        rdata
);

	point_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/ps_seq.sv */
// Load, exchange sort and output sequencer around the point store.
module ps_seq
	import ps_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sort_cfg_t     cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  point_t        in_pt,
	input  logic          in_final,
	output logic          out_valid,
	input  logic          out_ready,
	output point_t        out_pt,
	output logic          out_last,
	output logic          out_bad,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output point_t        mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  point_t        mem_rdata
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_RDI,
		S_FIRST,
		S_SCAN,
		S_WB,
		S_OUT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   rc_q;
	logic [AW-1:0]   i_q;
	point_t          held_q;
	sort_cfg_t       cfg_q;
	logic            pend_s1;
	logic [AW-1:0]   idx_s1;
	logic [CW-1:0]   cnt_next;
	logic            take_in;
	logic            move;
	logic            swap;
	logic signed [COORD_W-1:0] key_rd;
	logic signed [COORD_W-1:0] key_held;

	assign in_ready = (state_q == S_LOAD);
	assign take_in = in_valid && in_ready;
	assign move = (state_q == S_OUT) && pend_s1 && (!out_valid || out_ready);
	assign cnt_next = (cnt_q < CW'(MAX_POINTS)) ? cnt_q + CW'(1) : cnt_q;

	assign key_rd = cfg_q.by_y ? mem_rdata.y : mem_rdata.x;
	assign key_held = cfg_q.by_y ? held_q.y : held_q.x;
	assign swap = cfg_q.desc ? (key_held < key_rd) : (key_rd < key_held);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = in_pt;
		mem_re = 1'b0;
		mem_raddr = rc_q[AW-1:0];
		unique case (state_q)
			S_LOAD: begin
				mem_we = take_in && (cnt_q < CW'(MAX_POINTS));
			end
			S_RDI: begin
				mem_re = 1'b1;
				mem_raddr = i_q;
			end
			S_FIRST: begin
				mem_re = 1'b1;
			end
			S_SCAN: begin
				mem_we = pend_s1 && swap;
				mem_waddr = idx_s1;
				mem_wdata = held_q;
				mem_re = (rc_q < n_q);
			end
			S_WB: begin
				mem_we = 1'b1;
				mem_waddr = i_q;
				mem_wdata = held_q;
			end
			S_OUT: begin
				mem_re = (rc_q < n_q) && (!pend_s1 || move);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q <= '0;
			n_q <= '0;
			rc_q <= '0;
			i_q <= '0;
			pend_s1 <= 1'b0;
			idx_s1 <= '0;
			cfg_q <= '0;
			out_valid <= 1'b0;
			out_last <= 1'b0;
			out_bad <= 1'b0;
		end else begin
			if (move) begin
				out_valid <= 1'b1;
				out_pt <= mem_rdata;
				out_last <= (CW'(idx_s1) == n_q - CW'(1));
				out_bad <= cfg_q.bad;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (take_in) begin
						if (in_final) begin
							n_q <= cnt_next;
							cnt_q <= '0;
							cfg_q <= cfg;
							i_q <= '0;
							rc_q <= '0;
							pend_s1 <= 1'b0;
							if (cfg.bad || cnt_next < CW'(2)) begin
								state_q <= S_OUT;
							end else begin
								state_q <= S_RDI;
							end
						end else begin
							cnt_q <= cnt_next;
						end
					end
				end
				S_RDI: begin
					rc_q <= CW'(i_q) + CW'(1);
					state_q <= S_FIRST;
				end
				S_FIRST: begin
					held_q <= mem_rdata;
					pend_s1 <= 1'b1;
					idx_s1 <= rc_q[AW-1:0];
					rc_q <= rc_q + CW'(1);
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (pend_s1 && swap) begin
						held_q <= mem_rdata;
					end
					if (mem_re) begin
						pend_s1 <= 1'b1;
						idx_s1 <= rc_q[AW-1:0];
						rc_q <= rc_q + CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if ((CW+1)'(i_q) + (CW+1)'(2) < (CW+1)'(n_q)) begin
						i_q <= i_q + AW'(1);
						state_q <= S_RDI;
					end else begin
						rc_q <= '0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (mem_re) begin
						pend_s1 <= 1'b1;
						idx_s1 <= rc_q[AW-1:0];
						rc_q <= rc_q + CW'(1);
					end else if (move) begin
						pend_s1 <= 1'b0;
					end
					if (rc_q == n_q && !pend_s1) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_no_write_in_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> !mem_we)
		else $error("store written during output");

	a_scan_index_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && pend_s1) |-> (CW'(idx_s1) < n_q && idx_s1 > i_q))
		else $error("scan index outside the pass");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS))
		else $error("point count beyond capacity");

	a_output_from_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid) && $past(arst_n)) |-> $past(move))
		else $error("output appeared without a store read");
`endif

endmodule
